[rtl/itoa_pkg.sv]
// Shared types, codes and character constants for the integer to ASCII formatter.
`default_nettype none
package itoa_pkg;

	// conversion codes
	localparam logic [2:0] OP_S32  = 3'd0;
	localparam logic [2:0] OP_U32  = 3'd1;
	localparam logic [2:0] OP_S64  = 3'd2;
	localparam logic [2:0] OP_U64  = 3'd3;
	localparam logic [2:0] OP_HEXL = 3'd4;
	localparam logic [2:0] OP_HEXU = 3'd5;
	localparam logic [2:0] OP_CHR  = 3'd6;

	// digit cells in the chain: enough for the largest 64-bit decimal
	localparam int DEC_DIGITS = 20;
	localparam int MAG_W      = 64;
	localparam int HEX_BITS   = 32;
	localparam int REM_W      = 5;
	localparam int CNT_W      = 7;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_LA    = 8'h61;

	// per-cycle command broadcast to every digit cell
	typedef struct packed {
		logic clr;     // clear digit
		logic bshift;  // shift one bit in from the lower neighbor
		logic dabble;  // add 3 to digits >= 5 before the bit shift
		logic dshift;  // take the whole digit of the lower neighbor
	} itoa_cell_ctl_t;

	function automatic logic [7:0] itoa_digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] c;
		if (d < 4'd10)
			c = CH_ZERO + {4'h0, d};
		else
			c = (upper ? CH_UA : CH_LA) + {4'h0, d} - 8'd10;
		return c;
	endfunction

endpackage
`default_nettype wire

[rtl/itoa_bcd_cell.sv]
// One 4-bit digit cell of the shift-and-add-3 converter chain.
`default_nettype none
module itoa_bcd_cell
	import itoa_pkg::*;
(
	input  logic           clk,
	input  itoa_cell_ctl_t ctl,
	input  logic           bit_in,
	input  logic [3:0]     digit_in,
	output logic           bit_out,
	output logic [3:0]     digit
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	assign adj     = (ctl.dabble && digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign bit_out = adj[3];
	assign digit   = digit_q;

	always_ff @(posedge clk) begin
		if (ctl.clr)
			digit_q <= 4'd0;
		else if (ctl.bshift)
			digit_q <= {adj[2:0], bit_in};
		else if (ctl.dshift)
			digit_q <= digit_in;
	end

endmodule
`default_nettype wire

[rtl/integer_to_ascii_formatter_core.sv]
// Top level: integer to ASCII formatter built on a chain of BCD digit cells.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_ready  | opcode, value_low, value_high,
//          |           |                      | field_width, pad_with_zero
//  out     | output    | out_valid / out_ready| out_char, is_last
//
// One item at a time. Decimal codes shift all 64 magnitude bits in, one bit per cycle through all
// 20 digit cells with add-3 correction in every cell; hex codes shift 32 bits in without correction.
// Then 20 digit-shift steps walk the chain toward the top cell; each step emits one
// character or drops a leading zero. A minus sign is emitted before the conversion starts.
// A character item emits its byte, preceded by CR when the byte is a line feed.
// Reset (arst_n low) returns the sequencer to idle and drops a pending output item.
// The chain only advances through the emit phase when the output register is free, so
// a stalled consumer freezes the block once it has left the conversion phase.
`default_nettype none
module integer_to_ascii_formatter_core
	import itoa_pkg::*;
#(
	parameter int MAX_HEX_WIDTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [31:0] value_low,
	input  logic [31:0] value_high,
	input  logic [3:0]  field_width,
	input  logic        pad_with_zero,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_char,
	output logic        is_last
);

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MINUS  = 3'd1;
	localparam logic [2:0] ST_CONV   = 3'd2;
	localparam logic [2:0] ST_EMIT   = 3'd3;
	localparam logic [2:0] ST_CHR_CR = 3'd4;
	localparam logic [2:0] ST_CHR    = 3'd5;

	localparam logic [REM_W-1:0] MaxW     = REM_W'(MAX_HEX_WIDTH);
	localparam logic [REM_W-1:0] RemStart = REM_W'(DEC_DIGITS);
	localparam logic [CNT_W-1:0] DecBits  = CNT_W'(MAG_W);
	localparam logic [CNT_W-1:0] HexBits  = CNT_W'(HEX_BITS);

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [REM_W-1:0] rem_q;
	logic             lead_q;

	// item payload held for the duration of the conversion
	logic [MAG_W-1:0] mag_q;
	logic             hex_q;
	logic             upper_q;
	logic             pad_q;
	logic [REM_W-1:0] wid_q;

	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             out_last_q;

	logic             accept;
	logic             out_free;
	logic             emit_v;
	logic [7:0]       emit_c;
	logic             emit_l;
	logic             skip;
	logic [3:0]       top;
	itoa_cell_ctl_t   cell_ctl;

	logic [MAG_W-1:0] full;
	logic [MAG_W-1:0] neg_full;
	logic [31:0]      neg_low;
	logic [MAG_W-1:0] mag_in;
	logic [2:0]       state_in;
	logic [REM_W-1:0] fw5;
	logic [REM_W-1:0] wid_in;

	logic [DEC_DIGITS-1:0] cell_bit;
	logic [3:0]            cell_digit [DEC_DIGITS];

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign is_last   = out_last_q;
	assign top       = cell_digit[DEC_DIGITS-1];

	// ---------------------------------------------------------------------------
	// digit chain: cell 0 takes the magnitude MSB, each cell feeds the one above
	// ---------------------------------------------------------------------------
	for (genvar i = 0; i < DEC_DIGITS; i++) begin : g_cell
		if (i == 0) begin : g_first
			itoa_bcd_cell u_cell (
				.clk      (clk),
				.ctl      (cell_ctl),
				.bit_in   (mag_q[MAG_W-1]),
				.digit_in (4'd0),
				.bit_out  (cell_bit[i]),
				.digit    (cell_digit[i])
			);
		end else begin : g_rest
			itoa_bcd_cell u_cell (
				.clk      (clk),
				.ctl      (cell_ctl),
				.bit_in   (cell_bit[i-1]),
				.digit_in (cell_digit[i-1]),
				.bit_out  (cell_bit[i]),
				.digit    (cell_digit[i])
			);
		end
	end

	// ---------------------------------------------------------------------------
	// accept decode: magnitude, first state, effective hex width
	// ---------------------------------------------------------------------------
	assign full     = {value_high, value_low};
	assign neg_full = ~full + 64'd1;
	assign neg_low  = ~value_low + 32'd1;
	assign fw5      = {1'b0, field_width};
	assign wid_in   = (fw5 == '0) ? REM_W'(1) : ((fw5 > MaxW) ? MaxW : fw5);

	always_comb begin
		mag_in   = '0;
		state_in = ST_IDLE;
		unique case (opcode) inside
			OP_S32: begin
				mag_in   = value_low[31] ? {32'd0, neg_low} : {32'd0, value_low};
				state_in = value_low[31] ? ST_MINUS : ST_CONV;
			end
			OP_U32: begin
				mag_in   = {32'd0, value_low};
				state_in = ST_CONV;
			end
			OP_S64: begin
				mag_in   = value_high[31] ? neg_full : full;
				state_in = value_high[31] ? ST_MINUS : ST_CONV;
			end
			OP_U64: begin
				mag_in   = full;
				state_in = ST_CONV;
			end
			OP_HEXL, OP_HEXU: begin
				// hex bits go in MSB-first from the top of the shifter
				mag_in   = {value_low, 32'd0};
				state_in = ST_CONV;
			end
			OP_CHR: begin
				mag_in   = {56'd0, value_low[7:0]};
				state_in = (value_low[7:0] == CH_LF) ? ST_CHR_CR : ST_CHR;
			end
			default: begin
				// unused code: no characters
				mag_in   = '0;
				state_in = ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------------------
	// per-cycle control and character selection
	// ---------------------------------------------------------------------------
	always_comb begin
		cell_ctl     = '0;
		cell_ctl.clr = accept;
		emit_v       = 1'b0;
		emit_c       = CH_ZERO;
		emit_l       = 1'b0;
		skip         = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_MINUS: begin
				if (out_free) begin
					emit_v = 1'b1;
					emit_c = CH_MINUS;
				end
			end
			ST_CONV: begin
				cell_ctl.bshift = 1'b1;
				cell_ctl.dabble = !hex_q;
			end
			ST_EMIT: begin
				if (out_free) begin
					cell_ctl.dshift = 1'b1;
					if (lead_q && top == 4'd0 && rem_q > REM_W'(1)) begin
						// leading zero: padding for hex inside the width, else dropped
						skip = 1'b1;
						if (hex_q && rem_q <= wid_q) begin
							emit_v = 1'b1;
							emit_c = pad_q ? CH_ZERO : CH_SPACE;
						end
					end else begin
						emit_v = 1'b1;
						emit_c = itoa_digit_char(top, upper_q);
						emit_l = (rem_q == REM_W'(1));
					end
				end
			end
			ST_CHR_CR: begin
				if (out_free) begin
					emit_v = 1'b1;
					emit_c = CH_CR;
				end
			end
			ST_CHR: begin
				if (out_free) begin
					emit_v = 1'b1;
					emit_c = mag_q[7:0];
					emit_l = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
			lead_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= state_in;
						cnt_q   <= (opcode == OP_HEXL || opcode == OP_HEXU) ? HexBits : DecBits;
						rem_q   <= RemStart;
						lead_q  <= 1'b1;
					end
				end
				ST_MINUS: begin
					if (emit_v)
						state_q <= ST_CONV;
				end
				ST_CONV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1))
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (cell_ctl.dshift) begin
						rem_q <= rem_q - REM_W'(1);
						if (!skip)
							lead_q <= 1'b0;
						if (rem_q == REM_W'(1))
							state_q <= ST_IDLE;
					end
				end
				ST_CHR_CR: begin
					if (emit_v)
						state_q <= ST_CHR;
				end
				ST_CHR: begin
					if (emit_v)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item payload and magnitude shifter
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q   <= mag_in;
			hex_q   <= (opcode == OP_HEXL || opcode == OP_HEXU);
			upper_q <= (opcode == OP_HEXU);
			pad_q   <= pad_with_zero;
			wid_q   <= wid_in;
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[MAG_W-2:0], 1'b0};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit_v)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_v) begin
			out_char_q <= emit_c;
			out_last_q <= emit_l;
		end
	end

	// ---------------------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------------------
	// nothing may carry out of the top digit during conversion
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CONV |-> !cell_bit[DEC_DIGITS-1])
		else $error("digit chain overflow");

	// add-3 correction keeps every decimal digit in range
	a_dec_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !hex_q) |-> top <= 4'd9)
		else $error("decimal digit out of range");

	// the emit walk stays inside the chain
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> (rem_q != '0 && rem_q <= RemStart))
		else $error("emit position out of range");

	// conversion counter never idles at zero
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CONV |-> cnt_q != '0)
		else $error("conversion counter underflow");

	// a character is only emitted when the output register can take it
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit_v |-> out_free)
		else $error("emit into a full output register");

endmodule
`default_nettype wire
